// ===== hdl/wsp_pkg.sv =====
// Shared types, widths and constants of the waypoint speed profile block.
package wsp_pkg;

    // Field widths of the item and result transactions
    localparam int COORD_BITS = 20;
    localparam int SPEED_BITS = 16;
    localparam int REG_BITS   = 16;

    // Speed level must hold a register value as well as a saturated sum
    localparam int LVL_W = (SPEED_BITS > REG_BITS) ? SPEED_BITS : REG_BITS;
    localparam logic [LVL_W:0] SPEED_MAX = ((LVL_W + 1)'(1) << SPEED_BITS) - (LVL_W + 1)'(1);

    // Distance arithmetic
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int DSQ_W   = (SUM_W > 64) ? 64 : SUM_W;
    localparam int DSQ9_W  = DSQ_W + 4;
    localparam int THR_W   = 2 * (REG_BITS + 1);
    localparam int CMP_W   = (DSQ_W > THR_W) ? DSQ_W : THR_W;
    localparam logic [SUM_W-1:0] DSQ_CAP =
        SUM_W'(((SUM_W + 1)'(1) << DSQ_W) - (SUM_W + 1)'(1));

    // Queue between front and back; depth is a power of two
    localparam int MIDQ_DEPTH = 8;
    localparam int MIDQ_AW    = $clog2(MIDQ_DEPTH);
    localparam int CREDIT_W   = $clog2(MIDQ_DEPTH + 1);

    // Output buffer depth of the back part
    localparam int OBUF_DEPTH = 2;

    // Request codes
    localparam logic REQ_START  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_SPEED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ARRIVE_TOL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_ZONE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_MARGIN = 3'd5;

    // Configuration reset values
    localparam logic [REG_BITS-1:0] RST_MAX_SPEED    = 16'd32768;
    localparam logic [REG_BITS-1:0] RST_SLOW_SPEED   = 16'd6554;
    localparam logic [REG_BITS-1:0] RST_SPEED_STEP   = 16'd3277;
    localparam logic [REG_BITS-1:0] RST_ARRIVE_TOL   = 16'd256;
    localparam logic [REG_BITS-1:0] RST_SLOW_ZONE    = 16'd2048;
    localparam logic [REG_BITS-1:0] RST_BRAKE_MARGIN = 16'd1024;

    typedef struct packed {
        logic                          req_type;
        logic signed [COORD_BITS-1:0]  pos_x;
        logic signed [COORD_BITS-1:0]  pos_y;
        logic signed [COORD_BITS-1:0]  target_x;
        logic signed [COORD_BITS-1:0]  target_y;
    } t_in;

    typedef struct packed {
        logic [REG_BITS-1:0] speed_cmd;
        logic [1:0]          phase;
        logic                done_res;
        logic                overshoot;
    } t_out;

    typedef struct packed {
        logic [REG_BITS-1:0] max_speed;
        logic [REG_BITS-1:0] slow_speed;
        logic [REG_BITS-1:0] speed_step;
        logic [REG_BITS-1:0] arrive_tolerance;
        logic [REG_BITS-1:0] slow_zone;
        logic [REG_BITS-1:0] brake_margin;
    } t_cfg;

    // Classified item handed from front to back
    typedef struct packed {
        logic              req_type;
        logic [DSQ_W-1:0]  dsq;
        logic [DSQ9_W-1:0] dsq9;
    } t_mid;

    // Head of the front-to-back queue as seen by the back part
    typedef struct packed {
        logic valid;
        t_mid entry;
    } t_mid_rd;

    // Speed level as a command: keep the speed bits, then the result width
    function automatic logic [REG_BITS-1:0] speed_out(input logic [LVL_W-1:0] lvl);
        logic [LVL_W-1:0] masked;
        masked = lvl & SPEED_MAX[LVL_W-1:0];
        return REG_BITS'(masked);
    endfunction

endpackage

// ===== hdl/wsp_front.sv =====
// Front part: latches the goal and computes the squared distance of each item.
module wsp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  wsp_pkg::t_in  i_item,
    output logic          o_mid_valid,
    output wsp_pkg::t_mid o_mid
);
    import wsp_pkg::*;

    logic signed [COORD_BITS-1:0] r_goal_x;
    logic signed [COORD_BITS-1:0] r_goal_y;

    logic signed [COORD_BITS-1:0] w_ref_x;
    logic signed [COORD_BITS-1:0] w_ref_y;
    logic signed [DIFF_W-1:0]     w_dx;
    logic signed [DIFF_W-1:0]     w_dy;
    logic [SUM_W-1:0]             w_sum;

    logic              r_v1, r_v2, r_v3, r_v4;
    logic              r_req1, r_req2, r_req3, r_req4;
    logic [DIFF_W-1:0] r_ax, r_ay;
    logic [SQ_W-1:0]   r_sx, r_sy;
    logic [DSQ_W-1:0]  r_dsq3, r_dsq4;
    logic [DSQ9_W-1:0] r_dsq9;

    // A start item measures against its own target
    assign w_ref_x = (i_item.req_type == REQ_START) ? i_item.target_x : r_goal_x;
    assign w_ref_y = (i_item.req_type == REQ_START) ? i_item.target_y : r_goal_y;
    assign w_dx    = DIFF_W'(i_item.pos_x) - DIFF_W'(w_ref_x);
    assign w_dy    = DIFF_W'(i_item.pos_y) - DIFF_W'(w_ref_y);
    assign w_sum   = SUM_W'(r_sx) + SUM_W'(r_sy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x <= '0;
            r_goal_y <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
        end else begin
            if (i_accept && i_item.req_type == REQ_START) begin
                r_goal_x <= i_item.target_x;
                r_goal_y <= i_item.target_y;
            end
            r_v1 <= i_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        // Stage 1: absolute differences
        r_req1 <= i_item.req_type;
        r_ax   <= w_dx[DIFF_W-1] ? DIFF_W'(-w_dx) : DIFF_W'(w_dx);
        r_ay   <= w_dy[DIFF_W-1] ? DIFF_W'(-w_dy) : DIFF_W'(w_dy);
        // Stage 2: squares
        r_req2 <= r_req1;
        r_sx   <= SQ_W'(r_ax) * SQ_W'(r_ax);
        r_sy   <= SQ_W'(r_ay) * SQ_W'(r_ay);
        // Stage 3: sum, saturated to 43 bits
        r_req3 <= r_req2;
        r_dsq3 <= (w_sum > DSQ_CAP) ? DSQ_CAP[DSQ_W-1:0] : w_sum[DSQ_W-1:0];
        // Stage 4: nine times the distance for the one-third test
        r_req4 <= r_req3;
        r_dsq4 <= r_dsq3;
        r_dsq9 <= (DSQ9_W'(r_dsq3) << 3) + DSQ9_W'(r_dsq3);
    end

    assign o_mid_valid    = r_v4;
    assign o_mid.req_type = r_req4;
    assign o_mid.dsq      = r_dsq4;
    assign o_mid.dsq9     = r_dsq9;

endmodule

// ===== hdl/wsp_queue.sv =====
// Short queue of classified items between the front and back parts.
module wsp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  wsp_pkg::t_mid    i_data,
    input  logic             i_pop,
    output wsp_pkg::t_mid_rd o_rd
);
    import wsp_pkg::*;

    t_mid                r_mem [MIDQ_DEPTH];
    logic [MIDQ_AW-1:0]  r_wr;
    logic [MIDQ_AW-1:0]  r_rd;
    logic [CREDIT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + MIDQ_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + MIDQ_AW'(1);
            end
            r_cnt <= r_cnt + CREDIT_W'(i_push) - CREDIT_W'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_rd.valid = (r_cnt != '0);
    assign o_rd.entry = r_mem[r_rd];

endmodule

// ===== hdl/wsp_back.sv =====
// Back part: phase sequencer, speed update and output buffer.
module wsp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wsp_pkg::t_cfg    i_cfg,
    input  wsp_pkg::t_mid_rd i_rd,
    output logic             o_mid_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output wsp_pkg::t_out    o_result
);
    import wsp_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ACCEL = 2'd1,
        PH_DECEL = 2'd2,
        PH_FINAL = 2'd3
    } t_move;

    t_move            r_phase, n_phase;
    logic [LVL_W-1:0] r_speed, n_speed;
    logic [DSQ_W-1:0] r_start, n_start;
    logic [DSQ_W-1:0] r_prev, n_prev;
    logic             r_fs, n_fs;

    logic [THR_W-1:0] r_brake_sq;
    logic [THR_W-1:0] r_zone_sq;
    logic [THR_W-1:0] r_tol_sq;
    logic [REG_BITS:0] w_brake;

    t_out             r_obuf [OBUF_DEPTH];
    logic             r_ohead;
    logic [1:0]       r_ocnt;
    logic             w_out_pop;
    t_out             w_res;

    assign w_brake = (REG_BITS + 1)'(i_cfg.slow_zone) + (REG_BITS + 1)'(i_cfg.brake_margin);

    assign w_out_pop = i_pop && (r_ocnt != 2'd0);
    assign o_mid_pop = i_rd.valid && (r_ocnt != 2'(OBUF_DEPTH));
    assign o_empty   = (r_ocnt == 2'd0);
    assign o_result  = r_obuf[r_ohead];

    always_comb begin
        t_move             ph;
        logic [LVL_W-1:0]  spd;
        logic [LVL_W-1:0]  spd1;
        logic [LVL_W-1:0]  slow_l;
        logic [LVL_W-1:0]  step_l;
        logic [LVL_W:0]    sum;
        logic [DSQ_W-1:0]  strt;
        logic [DSQ_W-1:0]  prev;
        logic              fs;
        logic [CMP_W-1:0]  d_cmp;
        logic              far_third;
        logic              far_brake;
        logic              far_zone;
        logic              in_tol;

        ph     = r_phase;
        spd    = r_speed;
        strt   = r_start;
        prev   = r_prev;
        fs     = r_fs;
        slow_l = LVL_W'(i_cfg.slow_speed);
        step_l = LVL_W'(i_cfg.speed_step);

        // A start drops any running move and begins a new one
        if (i_rd.entry.req_type == REQ_START) begin
            ph   = PH_ACCEL;
            spd  = '0;
            strt = i_rd.entry.dsq;
            prev = '0;
            fs   = 1'b0;
        end

        d_cmp     = CMP_W'(i_rd.entry.dsq);
        far_third = i_rd.entry.dsq9 > DSQ9_W'(strt);
        far_brake = d_cmp > CMP_W'(r_brake_sq);
        far_zone  = d_cmp > CMP_W'(r_zone_sq);
        in_tol    = !(d_cmp > CMP_W'(r_tol_sq));

        n_phase = ph;
        n_speed = spd;
        n_start = strt;
        n_prev  = prev;
        n_fs    = fs;
        w_res   = '0;
        spd1    = spd;
        sum     = '0;

        if (ph == PH_IDLE) begin
            // Sample while idle: hold the state, answer with zero
            n_phase = r_phase;
        end else if (ph == PH_ACCEL && far_third && far_brake) begin
            if (spd < LVL_W'(i_cfg.max_speed)) begin
                sum  = (LVL_W + 1)'(spd) + (LVL_W + 1)'(step_l);
                spd1 = (sum > SPEED_MAX) ? SPEED_MAX[LVL_W-1:0] : sum[LVL_W-1:0];
            end
            n_speed         = spd1;
            w_res.speed_cmd = speed_out(spd1);
            w_res.phase     = PH_ACCEL;
        end else begin
            // Entering deceleration: lift the speed to at least the slow speed
            if (ph == PH_ACCEL && spd < slow_l) begin
                spd1 = slow_l;
            end
            if ((ph == PH_ACCEL || ph == PH_DECEL) && far_zone) begin
                if (spd1 > slow_l) begin
                    spd1 = (spd1 > step_l) ? spd1 - step_l : '0;
                end
                n_phase         = PH_DECEL;
                n_speed         = spd1;
                w_res.speed_cmd = speed_out(spd1);
                w_res.phase     = PH_DECEL;
            end else begin
                // First final sample skips the overshoot check
                if (ph != PH_FINAL) begin
                    fs = 1'b0;
                end
                w_res.phase = PH_FINAL;
                if (fs && i_rd.entry.dsq > prev) begin
                    n_phase         = PH_IDLE;
                    n_speed         = '0;
                    n_fs            = 1'b0;
                    w_res.overshoot = 1'b1;
                end else if (in_tol) begin
                    n_phase        = PH_IDLE;
                    n_speed        = '0;
                    n_fs           = 1'b0;
                    w_res.done_res = 1'b1;
                end else begin
                    n_phase         = PH_FINAL;
                    n_speed         = spd1;
                    n_prev          = i_rd.entry.dsq;
                    n_fs            = 1'b1;
                    w_res.speed_cmd = speed_out(slow_l);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_speed <= '0;
            r_start <= '0;
            r_prev  <= '0;
            r_fs    <= 1'b0;
            r_ohead <= 1'b0;
            r_ocnt  <= '0;
        end else begin
            if (o_mid_pop) begin
                r_phase <= n_phase;
                r_speed <= n_speed;
                r_start <= n_start;
                r_prev  <= n_prev;
                r_fs    <= n_fs;
            end
            if (w_out_pop) begin
                r_ohead <= ~r_ohead;
            end
            r_ocnt <= r_ocnt + 2'(o_mid_pop) - 2'(w_out_pop);
        end
        if (o_mid_pop) begin
            r_obuf[r_ohead ^ r_ocnt[0]] <= w_res;
        end
        // Squared thresholds follow the registers in the cycle after a write
        r_brake_sq <= THR_W'(w_brake) * THR_W'(w_brake);
        r_zone_sq  <= THR_W'(i_cfg.slow_zone) * THR_W'(i_cfg.slow_zone);
        r_tol_sq   <= THR_W'(i_cfg.arrive_tolerance) * THR_W'(i_cfg.arrive_tolerance);
    end

endmodule

// ===== hdl/waypoint_speed_profile.sv =====
// Top level of the waypoint speed profile: registers, flow control and the two parts.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+----------------------------
//  item     | in        | push / full              | i_item   (wsp_pkg::t_in)
//  result   | out       | empty / pop              | o_result (wsp_pkg::t_out)
//  config   | in        | i_cfg_we, no wait        | i_cfg_idx, i_cfg_data
//
// One item per cycle is sustained while full stays low. An accepted transaction passes
// the four front distance stages (difference, square, sum, times nine), then the queue
// and then the back part, which updates the move phase and speed level combinationally
// and writes the result into its output buffer, from where it reaches the ports.
// Reset is synchronous and needs no clearing pass. full rises once eight transactions
// sit before the back part; a stalled result side fills the two-entry buffer first.
module waypoint_speed_profile (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  wsp_pkg::t_in                    i_item,
    output logic                            empty,
    input  logic                            pop,
    output wsp_pkg::t_out                   o_result,
    input  logic                            i_cfg_we,
    input  logic [wsp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [wsp_pkg::REG_BITS-1:0]    i_cfg_data
);
    import wsp_pkg::*;

    t_cfg                r_cfg;
    logic [CREDIT_W-1:0] r_credit;

    logic    w_accept;
    logic    w_mid_valid;
    t_mid    w_mid;
    t_mid_rd w_mid_rd;
    logic    w_mid_pop;

    // Count transactions in the front pipeline and the queue; the queue can
    // never overflow because the front never runs ahead of this count.
    assign full     = (r_credit == CREDIT_W'(MIDQ_DEPTH));
    assign w_accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit              <= '0;
            r_cfg.max_speed        <= RST_MAX_SPEED;
            r_cfg.slow_speed       <= RST_SLOW_SPEED;
            r_cfg.speed_step       <= RST_SPEED_STEP;
            r_cfg.arrive_tolerance <= RST_ARRIVE_TOL;
            r_cfg.slow_zone        <= RST_SLOW_ZONE;
            r_cfg.brake_margin     <= RST_BRAKE_MARGIN;
        end else begin
            r_credit <= r_credit + CREDIT_W'(w_accept) - CREDIT_W'(w_mid_pop);
            if (i_cfg_we) begin
                // Drop writes to indexes beyond the register list
                case (i_cfg_idx)
                    CFG_MAX_SPEED:    r_cfg.max_speed        <= i_cfg_data;
                    CFG_SLOW_SPEED:   r_cfg.slow_speed       <= i_cfg_data;
                    CFG_SPEED_STEP:   r_cfg.speed_step       <= i_cfg_data;
                    CFG_ARRIVE_TOL:   r_cfg.arrive_tolerance <= i_cfg_data;
                    CFG_SLOW_ZONE:    r_cfg.slow_zone        <= i_cfg_data;
                    CFG_BRAKE_MARGIN: r_cfg.brake_margin     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Front: goal latch and squared distance pipeline
    wsp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_item      (i_item),
        .o_mid_valid (w_mid_valid),
        .o_mid       (w_mid)
    );

    // Decoupling queue
    wsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mid_valid),
        .i_data  (w_mid),
        .i_pop   (w_mid_pop),
        .o_rd    (w_mid_rd)
    );

    // Back: phase sequencer and output buffer
    wsp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_rd      (w_mid_rd),
        .o_mid_pop (w_mid_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

// ===== dv/waypoint_speed_profile_chk.sv =====
// Checker for the waypoint speed profile: tracks the move state and compares every result.
`timescale 1ns / 100ps
module waypoint_speed_profile_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  logic                            i_full,
    input  wsp_pkg::t_in                    i_item,
    input  logic                            i_empty,
    input  logic                            i_pop,
    input  wsp_pkg::t_out                   i_result,
    input  logic                            i_cfg_we,
    input  logic [wsp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [wsp_pkg::REG_BITS-1:0]    i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import wsp_pkg::*;

    typedef bit [63:0] t_dist;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_ACCEL = 2'd1;
    localparam logic [1:0] PH_DECEL = 2'd2;
    localparam logic [1:0] PH_FINAL = 2'd3;
    localparam t_dist      SPEED_CAP = (t_dist'(1) << SPEED_BITS) - 1;
    // d > S/3 on squares is dsq > start_dsq / 9
    localparam int         THIRD_SQ = 9;

    t_cfg                          regs;
    logic [1:0]                    move_phase;
    bit [31:0]                     speed_lvl;
    logic signed [COORD_BITS-1:0]  goal_x;
    logic signed [COORD_BITS-1:0]  goal_y;
    t_dist                         start_dsq;
    t_dist                         prev_dsq;
    bit                            in_final;
    t_out                          pending_cmds[$];
    int                            fail_count = 0;
    int                            pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic t_dist dist_sq_to_goal(input logic signed [COORD_BITS-1:0] px,
                                              input logic signed [COORD_BITS-1:0] py);
        longint dx;
        longint dy;
        dx = longint'(px) - longint'(goal_x);
        dy = longint'(py) - longint'(goal_y);
        return dx * dx + dy * dy;
    endfunction

    // Advance the move state by one transaction and return the command it yields
    function automatic t_out next_speed_command(input t_in item);
        t_dist dsq;
        t_dist brake;
        t_dist zone;
        t_dist tol;
        t_out  cmd;
        cmd = '0;
        if (item.req_type == REQ_START) begin
            goal_x     = item.target_x;
            goal_y     = item.target_y;
            start_dsq  = dist_sq_to_goal(item.pos_x, item.pos_y);
            prev_dsq   = '0;
            speed_lvl  = '0;
            in_final   = 1'b0;
            move_phase = PH_ACCEL;
        end else if (move_phase == PH_IDLE) begin
            return cmd;
        end
        dsq   = dist_sq_to_goal(item.pos_x, item.pos_y);
        brake = regs.slow_zone;
        brake = brake + regs.brake_margin;
        zone  = regs.slow_zone;
        tol   = regs.arrive_tolerance;

        if (move_phase == PH_ACCEL) begin
            if (dsq > start_dsq / THIRD_SQ && dsq > brake * brake) begin
                if (speed_lvl < regs.max_speed) begin
                    speed_lvl = speed_lvl + regs.speed_step;
                    if (speed_lvl > SPEED_CAP) speed_lvl = SPEED_CAP;
                end
                cmd.speed_cmd = REG_BITS'(speed_lvl & SPEED_CAP);
                cmd.phase     = PH_ACCEL;
                return cmd;
            end
            if (speed_lvl < regs.slow_speed) speed_lvl = regs.slow_speed;
            move_phase = PH_DECEL;
        end

        if (move_phase == PH_DECEL) begin
            if (dsq > zone * zone) begin
                if (speed_lvl > regs.slow_speed)
                    speed_lvl = (speed_lvl > regs.speed_step) ? speed_lvl - regs.speed_step : '0;
                cmd.speed_cmd = REG_BITS'(speed_lvl & SPEED_CAP);
                cmd.phase     = PH_DECEL;
                return cmd;
            end
            move_phase = PH_FINAL;
            in_final   = 1'b0;
        end

        cmd.phase = PH_FINAL;
        if (in_final && dsq > prev_dsq) begin
            move_phase    = PH_IDLE;
            speed_lvl     = '0;
            in_final      = 1'b0;
            cmd.overshoot = 1'b1;
            return cmd;
        end
        if (dsq <= tol * tol) begin
            move_phase   = PH_IDLE;
            speed_lvl    = '0;
            in_final     = 1'b0;
            cmd.done_res = 1'b1;
            return cmd;
        end
        prev_dsq      = dsq;
        in_final      = 1'b1;
        cmd.speed_cmd = regs.slow_speed;
        return cmd;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_out want;
        if (!i_rst_n) begin
            regs = '{max_speed: RST_MAX_SPEED, slow_speed: RST_SLOW_SPEED,
                     speed_step: RST_SPEED_STEP, arrive_tolerance: RST_ARRIVE_TOL,
                     slow_zone: RST_SLOW_ZONE, brake_margin: RST_BRAKE_MARGIN};
            move_phase = PH_IDLE;
            speed_lvl  = '0;
            goal_x     = '0;
            goal_y     = '0;
            start_dsq  = '0;
            prev_dsq   = '0;
            in_final   = 1'b0;
            pending_cmds.delete();
        end else begin
            // results first: none accepted this edge can belong to an item accepted now
            if (i_pop && !i_empty) begin
                if (pending_cmds.size() == 0) begin
                    report_mismatch("unrequested result", 64'(i_result), '0);
                end else begin
                    want = pending_cmds.pop_front();
                    if (i_result.speed_cmd !== want.speed_cmd)
                        report_mismatch("speed_cmd", 64'(i_result.speed_cmd), 64'(want.speed_cmd));
                    if (i_result.phase !== want.phase)
                        report_mismatch("phase", 64'(i_result.phase), 64'(want.phase));
                    if (i_result.done_res !== want.done_res)
                        report_mismatch("done_res", 64'(i_result.done_res), 64'(want.done_res));
                    if (i_result.overshoot !== want.overshoot)
                        report_mismatch("overshoot", 64'(i_result.overshoot),
                                        64'(want.overshoot));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_SPEED:    regs.max_speed        = i_cfg_data;
                    CFG_SLOW_SPEED:   regs.slow_speed       = i_cfg_data;
                    CFG_SPEED_STEP:   regs.speed_step       = i_cfg_data;
                    CFG_ARRIVE_TOL:   regs.arrive_tolerance = i_cfg_data;
                    CFG_SLOW_ZONE:    regs.slow_zone        = i_cfg_data;
                    CFG_BRAKE_MARGIN: regs.brake_margin     = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_push && !i_full) pending_cmds.push_back(next_speed_command(i_item));
        end
        pending_count = pending_cmds.size();
    end

endmodule

// ===== dv/waypoint_speed_profile_tb.sv =====
// Top of the waypoint speed profile testbench: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 100ps
module waypoint_speed_profile_tb;
    import wsp_pkg::*;

    localparam int     ITEM_TARGET    = 650;
    localparam int     N_SETTINGS     = 6;
    localparam int     HOLD_CYCLES    = 100;
    localparam int     DRAIN_CYCLES   = 16;
    // No transaction for this many cycles means the block has hung; the slowest
    // legal stretch is the long result hold plus a long gap, well under this.
    localparam int     WATCHDOG_LIMIT = 3000;
    localparam longint COORD_HI       = (longint'(1) << (COORD_BITS - 1)) - 1;
    localparam longint COORD_LO       = -COORD_HI - 1;
    // Indexes beyond the last register: writes there must leave everything alone
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_BRAKE_MARGIN + CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_BRAKE_MARGIN + CFG_IDX_W'(2);

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  push       = 1'b0;
    logic                  pop        = 1'b0;
    t_in                   i_item     = '0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [REG_BITS-1:0]   i_cfg_data = '0;
    logic                  full;
    logic                  empty;
    t_out                  o_result;

    int fail_count;
    int pending;
    int items_sent   = 0;
    int quiet_cycles = 0;
    bit tx_eager     = 1'b0;   // sender offers back to back
    bit rx_eager     = 1'b0;   // receiver pops every cycle
    bit hold_req     = 1'b0;   // ask the receiver for one long hold-off

    waypoint_speed_profile dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    waypoint_speed_profile_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_item       (i_item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (o_result),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    function automatic logic signed [COORD_BITS-1:0] clip_coord(input longint v);
        if (v > COORD_HI) return COORD_BITS'(COORD_HI);
        if (v < COORD_LO) return COORD_BITS'(COORD_LO);
        return COORD_BITS'(v);
    endfunction

    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        return COORD_BITS'($urandom());
    endfunction

    function automatic longint jitter(input int amp);
        return longint'($urandom_range(0, 2 * amp)) - amp;
    endfunction

    function automatic t_in random_item();
        logic [95:0] bits;
        t_in         r;
        bits = {$urandom(), $urandom(), $urandom()};
        r    = bits[$bits(t_in)-1:0];
        return r;
    endfunction

    // Drop push and scribble on the payload for the given number of cycles
    task automatic idle_sender(input int cycles);
        int n;
        if (cycles == 0) return;
        @(negedge i_clk);
        push   <= 1'b0;
        i_item <= random_item();
        for (n = 1; n < cycles; n++) begin
            @(negedge i_clk);
            i_item <= random_item();
        end
    endtask

    // Offer one transaction and hold it until the block takes it
    task automatic send_item(input t_in it);
        @(negedge i_clk);
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        items_sent++;
        if (!tx_eager) idle_sender(gap_len());
    endtask

    task automatic send_start(input longint px, input longint py,
                              input longint tx, input longint ty);
        t_in it;
        it.req_type = REQ_START;
        it.pos_x    = clip_coord(px);
        it.pos_y    = clip_coord(py);
        it.target_x = clip_coord(tx);
        it.target_y = clip_coord(ty);
        send_item(it);
    endtask

    // Target fields are ignored on samples; fill them with noise anyway
    task automatic send_sample(input longint px, input longint py);
        t_in it;
        it.req_type = REQ_SAMPLE;
        it.pos_x    = clip_coord(px);
        it.pos_y    = clip_coord(py);
        it.target_x = rand_coord();
        it.target_y = rand_coord();
        send_item(it);
    endtask

    // Start at target + offset and walk in straight steps onto the target.
    // With turn_back the walk reverses half way, which provokes an overshoot
    // once the final phase has begun.
    task automatic drive_move(input longint tx, input longint ty, input longint ox,
                              input longint oy, input int steps, input bit turn_back,
                              input int ja);
        int k;
        int idx;
        send_start(tx + ox, ty + oy, tx, ty);
        for (k = 1; k <= steps; k++) begin
            idx = (turn_back && 2 * k > steps) ? steps - k : k;
            send_sample(tx + ox * (steps - idx) / steps + jitter(ja),
                        ty + oy * (steps - idx) / steps + jitter(ja));
        end
    endtask

    // One random stretch: mostly full moves, the rest noise and broken moves
    task automatic random_episode();
        int     kind;
        int     mag;
        longint ox;
        longint oy;
        kind     = $urandom_range(0, 99);
        tx_eager = ($urandom_range(0, 3) == 0);
        mag      = 1 << $urandom_range(6, COORD_BITS);
        ox       = longint'($urandom_range(0, 2 * mag)) - mag;
        oy       = longint'($urandom_range(0, 2 * mag)) - mag;
        if (kind < 70) begin
            drive_move(rand_coord(), rand_coord(), ox, oy, $urandom_range(2, 16),
                       $urandom_range(0, 3) == 0,
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 200) : 0);
        end else if (kind < 78) begin
            repeat ($urandom_range(1, 3)) send_sample(rand_coord(), rand_coord());
        end else if (kind < 88) begin
            // abandon half way; the next start drops this move
            send_start(ox, oy, rand_coord(), rand_coord());
            repeat ($urandom_range(1, 3)) send_sample(ox / 2, oy / 2);
        end else begin
            send_item(random_item());
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
    endtask

    task automatic load_settings(input t_cfg c);
        write_reg(CFG_MAX_SPEED,    c.max_speed);
        write_reg(CFG_SLOW_SPEED,   c.slow_speed);
        write_reg(CFG_SPEED_STEP,   c.speed_step);
        write_reg(CFG_ARRIVE_TOL,   c.arrive_tolerance);
        write_reg(CFG_SLOW_ZONE,    c.slow_zone);
        write_reg(CFG_BRAKE_MARGIN, c.brake_margin);
        write_reg(CFG_SPARE_LO,     REG_BITS'($urandom()));
        write_reg(CFG_SPARE_HI,     REG_BITS'($urandom()));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Every transaction yields a result, so an empty scoreboard means the block is idle
    task automatic wait_idle();
        idle_sender(1);
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin : stimulus
        t_cfg setting;
        int   p;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (p = 0; p < N_SETTINGS; p++) begin
            if (p > 0) begin
                wait_idle();
                case (p)
                    1: setting = '0;
                    2: setting = '1;
                    3: setting = '{max_speed: 16'hFFFF, slow_speed: 16'd1000,
                                   speed_step: 16'd40000, arrive_tolerance: 16'd200,
                                   slow_zone: 16'd3000, brake_margin: 16'd500};
                    default: begin
                        setting.max_speed        = REG_BITS'($urandom_range(0, 65535));
                        setting.slow_speed       = REG_BITS'($urandom_range(0, 65535));
                        setting.speed_step       = REG_BITS'($urandom_range(0, 8000));
                        setting.arrive_tolerance = REG_BITS'($urandom_range(0, 2000));
                        setting.slow_zone        = REG_BITS'($urandom_range(0, 20000));
                        setting.brake_margin     = REG_BITS'($urandom_range(0, 20000));
                    end
                endcase
                load_settings(setting);
            end

            if (p == 0) begin
                // samples with no move under way
                send_sample(0, 0);
                send_sample(COORD_HI, COORD_LO);
                // longest move the coordinates allow, one accelerating sample, then one
                // sample that falls through all three phases and arrives
                send_start(COORD_LO, COORD_LO, COORD_HI, COORD_HI);
                send_sample(0, 0);
                send_sample(COORD_HI - 100, COORD_HI - 100);
                // start right on the target
                send_start(1000, -1000, 1000, -1000);
                // complete trapezoid
                drive_move(-5000, 7000, 40000, 0, 8, 1'b0, 0);
                // start while moving
                send_start(0, 0, 200000, 200000);
                send_sample(20000, 20000);
                // decelerate, enter final, then move away: overshoot
                send_start(2500, 0, 0, 0);
                send_sample(1800, 0);
                send_sample(1000, 0);
                send_sample(1500, 0);
                send_sample(1000, 0);
                // start inside the slow zone: first final sample skips the growth check
                send_start(1000, 0, 0, 0);
                send_sample(100, 0);

                // hold results back while the sender keeps pushing, so full rises
                hold_req = 1'b1;
                tx_eager = 1'b1;
                repeat (3) drive_move(rand_coord(), rand_coord(), 30000, -20000, 10, 1'b0, 0);
                tx_eager = 1'b0;
            end

            // saturating climb, then a fall floored at zero
            if (p == 3) drive_move(0, 0, 400000, -300000, 10, 1'b0, 0);

            while (items_sent < (p + 1) * ITEM_TARGET / N_SETTINGS) random_episode();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Result side: random stalls, eager stretches, and one long hold on request
    initial begin : result_sink
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end else begin
                pop <= 1'b1;
                if (!rx_eager) stall = gap_len();
            end
            if ($urandom_range(0, 149) == 0) rx_eager = !rx_eager;
        end
    end

    // Count cycles without a transaction on either side; give up at the limit
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
hdl/wsp_pkg.sv
hdl/wsp_front.sv
hdl/wsp_queue.sv
hdl/wsp_back.sv
hdl/waypoint_speed_profile.sv
dv/waypoint_speed_profile_chk.sv
dv/waypoint_speed_profile_tb.sv
